[rtl/core/pfdf_pkg.sv]
// Shared types and constants for the page framebuffer display feeder.
`default_nettype none

package pfdf_pkg;

  // Default geometry.
  localparam int unsigned DefPanelWidth  = 128;
  localparam int unsigned DefPanelHeight = 64;
  localparam int unsigned DefChunkBytes  = 128;

  localparam int unsigned PageRows = 8;
  localparam int unsigned PageW    = 3;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] REG_CMD_CTRL  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_DATA_CTRL = 1'b1;

  localparam logic [7:0] CmdCtrlReset  = 8'h00;
  localparam logic [7:0] DataCtrlReset = 8'h40;

  // Command transfer: control byte, page address, column low, column high.
  localparam logic [1:0] CMD_POS_CTRL = 2'd0;
  localparam logic [1:0] CMD_POS_PAGE = 2'd1;
  localparam logic [1:0] CMD_POS_LOW  = 2'd2;
  localparam logic [1:0] CMD_POS_HIGH = 2'd3;
  localparam logic [7:0] CmdPageBase  = 8'hB0;
  localparam logic [7:0] CmdColLow    = 8'h00;
  localparam logic [7:0] CmdColHigh   = 8'h10;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FLUSH = 2'd2
  } pfdf_op_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_FINISH
  } pfdf_state_e;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic read;
    logic finish;
  } pfdf_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } pfdf_status_t;

endpackage

`default_nettype wire

[rtl/core/page_framebuffer_display_feeder.sv]
// Top level of the page framebuffer display feeder.
`default_nettype none

// Monochrome page framebuffer with a flush byte stream for a display bus.
// Requests: start_i with opcode_i (draw pixel, clear, next flush byte) and
// pixel_x_i/pixel_y_i/pixel_on_i are taken when start_i is high and busy_o
// is low. Each request gives exactly one result, shown for one cycle with
// done_o high; the receiver cannot stall, so it must take it then.
// Draw and next-byte requests: accept, memory read, finish; done_o rises
// after the finish step, from a register, and busy_o is already low then,
// so a new request can be taken as done_o rises. The single-port store
// read and read-modify-write hold off a new request until the last ends.
// Clear request: sweeps the store one byte per cycle, PANEL_WIDTH*8 bytes
// (1024 by default), then a finish step before done_o.
// Reset: control, config and flush position registers return to defaults,
// and the store is swept to zero with busy_o high, issuing no result.
// Config: cfg_we_i writes register cfg_idx_i (0 command control byte,
// 1 data control byte) at once; write only while no request is in flight.
module page_framebuffer_display_feeder #(
  parameter int unsigned PanelWidth  = pfdf_pkg::DefPanelWidth,
  parameter int unsigned PanelHeight = pfdf_pkg::DefPanelHeight,
  parameter int unsigned ChunkBytes  = pfdf_pkg::DefChunkBytes
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [7:0]                    pixel_x_i,
  input  wire logic [7:0]                    pixel_y_i,
  input  wire logic                          pixel_on_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [pfdf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [pfdf_pkg::CfgDataW-1:0] cfg_wdata_i,
  output logic                               done_o,
  output logic [7:0]                         bus_byte_o,
  output logic                               byte_valid_o,
  output logic                               transfer_start_o,
  output logic                               transfer_end_o,
  output logic                               flush_done_o,
  output logic                               pixel_ignored_o
);
  import pfdf_pkg::*;

  pfdf_cmd_t    cmd;
  pfdf_status_t status;

  pfdf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  pfdf_datapath #(
    .PanelWidth  (PanelWidth),
    .PanelHeight (PanelHeight),
    .ChunkBytes  (ChunkBytes)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .opcode_i         (opcode_i),
    .pixel_x_i        (pixel_x_i),
    .pixel_y_i        (pixel_y_i),
    .pixel_on_i       (pixel_on_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .bus_byte_o       (bus_byte_o),
    .byte_valid_o     (byte_valid_o),
    .transfer_start_o (transfer_start_o),
    .transfer_end_o   (transfer_end_o),
    .flush_done_o     (flush_done_o),
    .pixel_ignored_o  (pixel_ignored_o)
  );

endmodule

`default_nettype wire

[rtl/core/pfdf_ctrl.sv]
// Sequencer: accepts requests, runs store sweeps, steps read and finish.
`default_nettype none

module pfdf_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [1:0]             opcode_i,
  input  wire pfdf_pkg::pfdf_status_t status_i,
  output pfdf_pkg::pfdf_cmd_t         cmd_o,
  output logic                        busy_o
);
  import pfdf_pkg::*;

  pfdf_state_e state_q, state_d;
  logic        clr_pending_q, clr_pending_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      clr_pending_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_pending_q <= clr_pending_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    clr_pending_d = clr_pending_q;
    cmd_o         = '0;
    busy_o        = 1'b1;
    unique case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          clr_pending_d = 1'b0;
          // reset sweep returns quietly, a clear request still reports
          state_d = clr_pending_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (opcode_i == OP_CLEAR) begin
            clr_pending_d = 1'b1;
            state_d       = ST_SWEEP;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> busy_o)
    else $error("accepted request did not raise busy");

  a_read_then_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> cmd_o.finish)
    else $error("memory read not followed by finish");

  a_no_stray_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clr_pending_q && (state_q == ST_IDLE || state_q == ST_READ)))
    else $error("clear pending outside a sweep");
`endif

endmodule

`default_nettype wire

[rtl/core/pfdf_datapath.sv]
// Framebuffer memory, flush position counters, config and result registers.
`default_nettype none

module pfdf_datapath #(
  parameter int unsigned PanelWidth  = pfdf_pkg::DefPanelWidth,
  parameter int unsigned PanelHeight = pfdf_pkg::DefPanelHeight,
  parameter int unsigned ChunkBytes  = pfdf_pkg::DefChunkBytes
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pfdf_pkg::pfdf_cmd_t           cmd_i,
  output pfdf_pkg::pfdf_status_t             status_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [7:0]                    pixel_x_i,
  input  wire logic [7:0]                    pixel_y_i,
  input  wire logic                          pixel_on_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [pfdf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [pfdf_pkg::CfgDataW-1:0] cfg_wdata_i,
  output logic                               done_o,
  output logic [7:0]                         bus_byte_o,
  output logic                               byte_valid_o,
  output logic                               transfer_start_o,
  output logic                               transfer_end_o,
  output logic                               flush_done_o,
  output logic                               pixel_ignored_o
);
  import pfdf_pkg::*;

  localparam int unsigned StoreBytes = PanelWidth * PageRows;
  localparam int unsigned PageCount  = (PanelHeight + PageRows - 1) / PageRows;
  localparam int unsigned AW = $clog2(StoreBytes);
  localparam int unsigned CW = $clog2(PanelWidth);
  localparam int unsigned OW = $clog2(ChunkBytes + 1);

  // Config registers
  logic [7:0] cmd_ctrl_q, data_ctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ctrl_q  <= CmdCtrlReset;
      data_ctrl_q <= DataCtrlReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CMD_CTRL:  cmd_ctrl_q  <= cfg_wdata_i;
        REG_DATA_CTRL: data_ctrl_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Latched request
  logic [1:0]    op_q;
  logic [2:0]    bit_q;
  logic          on_q;
  logic          in_range_q;
  logic [AW-1:0] addr_q, addr_d;
  logic          in_range;

  // Flush position
  logic [PageW-1:0] fl_page_q, fl_page_d;
  logic             fl_cmd_q, fl_cmd_d;
  logic [1:0]       fl_cidx_q, fl_cidx_d;
  logic [OW-1:0]    fl_off_q, fl_off_d;
  logic [CW-1:0]    fl_col_q, fl_col_d;

  assign in_range = ({1'b0, pixel_x_i} < 9'(PanelWidth)) &&
                    ({1'b0, pixel_y_i} < 9'(PanelHeight));

  always_comb begin
    if (opcode_i == OP_FLUSH) begin
      addr_d = AW'(fl_page_q) * AW'(PanelWidth) + AW'(fl_col_q);
    end else begin
      addr_d = AW'(pixel_y_i[5:3]) * AW'(PanelWidth) + AW'(pixel_x_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= opcode_i;
      bit_q      <= pixel_y_i[2:0];
      on_q       <= pixel_on_i;
      in_range_q <= in_range;
      addr_q     <= addr_d;
    end
  end

  // Framebuffer memory and clearing sweep
  logic [7:0]    mem_q [StoreBytes];
  logic [7:0]    rdata_q;
  logic [AW-1:0] sweep_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mask;

  assign status_o.sweep_last = (sweep_q == AW'(StoreBytes - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= status_o.sweep_last ? '0 : sweep_q + AW'(1);
    end
  end

  assign mask      = 8'(1) << bit_q;
  assign mem_we    = cmd_i.sweep || (cmd_i.finish && (op_q == OP_DRAW) && in_range_q);
  assign mem_waddr = cmd_i.sweep ? sweep_q : addr_q;
  assign mem_wdata = cmd_i.sweep ? 8'h00 : (on_q ? (rdata_q | mask) : (rdata_q & ~mask));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.read) begin
      rdata_q <= mem_q[addr_q];
    end
  end

  // Flush byte and next position
  logic [7:0] fl_byte;
  logic       fl_start, fl_end, fl_done;
  logic       last_col;

  assign last_col = (fl_col_q == CW'(PanelWidth - 1));

  always_comb begin
    fl_byte   = 8'h00;
    fl_start  = 1'b0;
    fl_end    = 1'b0;
    fl_done   = 1'b0;
    fl_page_d = fl_page_q;
    fl_cmd_d  = fl_cmd_q;
    fl_cidx_d = fl_cidx_q;
    fl_off_d  = fl_off_q;
    fl_col_d  = fl_col_q;
    if (fl_cmd_q) begin
      unique case (fl_cidx_q)
        CMD_POS_CTRL: begin
          fl_byte  = cmd_ctrl_q;
          fl_start = 1'b1;
        end
        CMD_POS_PAGE: fl_byte = CmdPageBase | 8'(fl_page_q);
        CMD_POS_LOW:  fl_byte = CmdColLow;
        CMD_POS_HIGH: begin
          fl_byte = CmdColHigh;
          fl_end  = 1'b1;
        end
        default: ;
      endcase
      if (fl_cidx_q == CMD_POS_HIGH) begin
        fl_cmd_d = 1'b0;
        fl_off_d = '0;
        fl_col_d = '0;
      end else begin
        fl_cidx_d = fl_cidx_q + 2'd1;
      end
    end else if (fl_off_q == '0) begin
      fl_byte  = data_ctrl_q;
      fl_start = 1'b1;
      fl_off_d = OW'(1);
    end else begin
      fl_byte = rdata_q;
      fl_end  = (fl_off_q == OW'(ChunkBytes)) || last_col;
      if (last_col) begin
        // page sequence complete
        fl_cmd_d  = 1'b1;
        fl_cidx_d = CMD_POS_CTRL;
        if (fl_page_q == PageW'(PageCount - 1)) begin
          fl_page_d = '0;
          fl_done   = 1'b1;
        end else begin
          fl_page_d = fl_page_q + PageW'(1);
        end
      end else begin
        fl_col_d = fl_col_q + CW'(1);
        fl_off_d = (fl_off_q == OW'(ChunkBytes)) ? '0 : fl_off_q + OW'(1);
      end
    end
  end

  logic fl_step;
  assign fl_step = cmd_i.finish && (op_q == OP_FLUSH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl_page_q <= '0;
      fl_cmd_q  <= 1'b1;
      fl_cidx_q <= CMD_POS_CTRL;
      fl_off_q  <= '0;
      fl_col_q  <= '0;
    end else if (fl_step) begin
      fl_page_q <= fl_page_d;
      fl_cmd_q  <= fl_cmd_d;
      fl_cidx_q <= fl_cidx_d;
      fl_off_q  <= fl_off_d;
      fl_col_q  <= fl_col_d;
    end
  end

  // Result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      bus_byte_o       <= fl_step ? fl_byte : 8'h00;
      byte_valid_o     <= fl_step;
      transfer_start_o <= fl_step && fl_start;
      transfer_end_o   <= fl_step && fl_end;
      flush_done_o     <= fl_step && fl_done;
      pixel_ignored_o  <= (op_q == OP_DRAW) && !in_range_q;
    end
  end

`ifndef SYNTHESIS
  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd_i.finish))
    else $error("result strobe without a finish step");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fl_col_q <= CW'(PanelWidth - 1))
    else $error("flush column past panel width");

  a_off_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fl_off_q <= OW'(ChunkBytes))
    else $error("chunk offset past chunk length");
`endif

endmodule

`default_nettype wire

[sim/page_framebuffer_display_feeder_checker.sv]
// Result predictor and scoreboard for the page framebuffer display feeder.
module page_framebuffer_display_feeder_checker
  import pfdf_pkg::*;
#(
  parameter int unsigned PanelWidth  = DefPanelWidth,
  parameter int unsigned PanelHeight = DefPanelHeight,
  parameter int unsigned ChunkBytes  = DefChunkBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          pixel_x_i,
  input  logic [7:0]          pixel_y_i,
  input  logic                pixel_on_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                done_i,
  input  logic [7:0]          bus_byte_i,
  input  logic                byte_valid_i,
  input  logic                transfer_start_i,
  input  logic                transfer_end_i,
  input  logic                flush_done_i,
  input  logic                pixel_ignored_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         flush_rounds_o
);

  localparam int unsigned StoreBytes = PanelWidth * PageRows;
  localparam int unsigned PageCount  = (PanelHeight + PageRows - 1) / PageRows;
  localparam int unsigned CmdLen     = 4;
  localparam int unsigned ChunkCount = (PanelWidth + ChunkBytes - 1) / ChunkBytes;
  localparam int unsigned PageSeqLen = CmdLen + PanelWidth + ChunkCount;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       byte_valid;
    logic       transfer_start;
    logic       transfer_end;
    logic       flush_done;
    logic       pixel_ignored;
  } feeder_result_t;

  logic [7:0]     pixel_bytes [StoreBytes];
  int unsigned    cur_page;
  int unsigned    cur_pos;
  logic [7:0]     cmd_ctrl;
  logic [7:0]     data_ctrl;
  feeder_result_t expected_results [$];
  int unsigned    fails;
  int unsigned    rounds;

  // Next byte of the endless flush stream; advances the page/position.
  function automatic feeder_result_t next_flush_byte();
    feeder_result_t res;
    int unsigned    d, chunk, off, first_col, len, idx;
    res = '0;
    res.byte_valid = 1'b1;
    if (cur_pos < CmdLen) begin
      case (cur_pos[1:0])
        CMD_POS_CTRL: begin
          res.bus_byte       = cmd_ctrl;
          res.transfer_start = 1'b1;
        end
        CMD_POS_PAGE: res.bus_byte = CmdPageBase | {5'd0, cur_page[2:0]};
        CMD_POS_LOW:  res.bus_byte = CmdColLow;
        default: begin
          res.bus_byte     = CmdColHigh;
          res.transfer_end = 1'b1;
        end
      endcase
    end else begin
      // data part: chunks of (control byte + up to ChunkBytes columns)
      d         = cur_pos - CmdLen;
      chunk     = d / (ChunkBytes + 1);
      off       = d % (ChunkBytes + 1);
      first_col = chunk * ChunkBytes;
      len       = PanelWidth - first_col;
      if (len > ChunkBytes) len = ChunkBytes;
      if (off == 0) begin
        res.bus_byte       = data_ctrl;
        res.transfer_start = 1'b1;
      end else begin
        idx = cur_page * PanelWidth + first_col + off - 1;
        if (idx < StoreBytes) res.bus_byte = pixel_bytes[idx];
      end
      if (off == len) res.transfer_end = 1'b1;
    end
    cur_pos++;
    if (cur_pos >= PageSeqLen) begin
      cur_pos = 0;
      cur_page++;
      if (cur_page >= PageCount) begin
        cur_page       = 0;
        res.flush_done = 1'b1;
        rounds++;
      end
    end
    return res;
  endfunction

  function automatic feeder_result_t predict_request(input logic [1:0] op, input logic [7:0] x,
                                                     input logic [7:0] y, input logic on);
    feeder_result_t res;
    int unsigned    idx;
    res = '0;
    case (op)
      OP_DRAW: begin
        if (x >= PanelWidth || y >= PanelHeight) begin
          res.pixel_ignored = 1'b1;
        end else begin
          idx = (y / PageRows) * PanelWidth + x;
          if (idx < StoreBytes) pixel_bytes[idx][y % PageRows] = on;
        end
      end
      OP_CLEAR: begin
        foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
      end
      OP_FLUSH: res = next_flush_byte();
      default: ;  // unused opcode: no effect, all-zero result
    endcase
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    feeder_result_t got, want;
    if (!rst_ni) begin
      foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
      cur_page  = 0;
      cur_pos   = 0;
      cmd_ctrl  = CmdCtrlReset;
      data_ctrl = DataCtrlReset;
      expected_results.delete();
      fails  = 0;
      rounds = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
      flush_rounds_o <= 0;
    end else begin
      // retire the oldest request before queuing one accepted at this edge
      if (done_i) begin
        got = {bus_byte_i, byte_valid_i, transfer_start_i, transfer_end_i,
               flush_done_i, pixel_ignored_i};
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: bus_byte %0h", bus_byte_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          compare_field("bus_byte", want.bus_byte, got.bus_byte);
          compare_field("byte_valid", want.byte_valid, got.byte_valid);
          compare_field("transfer_start", want.transfer_start, got.transfer_start);
          compare_field("transfer_end", want.transfer_end, got.transfer_end);
          compare_field("flush_done", want.flush_done, got.flush_done);
          compare_field("pixel_ignored", want.pixel_ignored, got.pixel_ignored);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CMD_CTRL:  cmd_ctrl  = cfg_wdata_i;
          REG_DATA_CTRL: data_ctrl = cfg_wdata_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        expected_results.push_back(predict_request(opcode_i, pixel_x_i, pixel_y_i,
                                                   pixel_on_i));
      fail_count_o   <= fails;
      pending_o      <= expected_results.size();
      flush_rounds_o <= rounds;
    end
  end

endmodule

[sim/page_framebuffer_display_feeder_tb.sv]
// Testbench top for the page framebuffer display feeder: stimulus and verdict.
module page_framebuffer_display_feeder_tb;
  import pfdf_pkg::*;

  localparam int unsigned PanelWidth  = DefPanelWidth;
  localparam int unsigned PanelHeight = DefPanelHeight;
  localparam int unsigned ChunkBytes  = DefChunkBytes;
  localparam logic [1:0]  OpUnused    = 2'd3;
  localparam int unsigned PhaseCount  = 4;
  localparam int unsigned PhaseItems  = 345;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 400000;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [1:0]          opcode_i;
  logic [7:0]          pixel_x_i;
  logic [7:0]          pixel_y_i;
  logic                pixel_on_i;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                done_o;
  logic [7:0]          bus_byte_o;
  logic                byte_valid_o;
  logic                transfer_start_o;
  logic                transfer_end_o;
  logic                flush_done_o;
  logic                pixel_ignored_o;

  int unsigned mismatch_count;
  int unsigned results_outstanding;
  int unsigned flush_rounds;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned op_counts [4] = '{default: 0};

  page_framebuffer_display_feeder #(
    .PanelWidth (PanelWidth),
    .PanelHeight(PanelHeight),
    .ChunkBytes (ChunkBytes)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .pixel_on_i      (pixel_on_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .bus_byte_o      (bus_byte_o),
    .byte_valid_o    (byte_valid_o),
    .transfer_start_o(transfer_start_o),
    .transfer_end_o  (transfer_end_o),
    .flush_done_o    (flush_done_o),
    .pixel_ignored_o (pixel_ignored_o)
  );

  page_framebuffer_display_feeder_checker #(
    .PanelWidth (PanelWidth),
    .PanelHeight(PanelHeight),
    .ChunkBytes (ChunkBytes)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .opcode_i        (opcode_i),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .pixel_on_i      (pixel_on_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_i          (done_o),
    .bus_byte_i      (bus_byte_o),
    .byte_valid_i    (byte_valid_o),
    .transfer_start_i(transfer_start_o),
    .transfer_end_i  (transfer_end_o),
    .flush_done_i    (flush_done_o),
    .pixel_ignored_i (pixel_ignored_o),
    .fail_count_o    (mismatch_count),
    .pending_o       (results_outstanding),
    .flush_rounds_o  (flush_rounds)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Holds the request until the block takes it; start_i stays high after.
  task automatic send_request(input logic [1:0] op, input logic [7:0] x,
                              input logic [7:0] y, input logic on);
    start_i    <= 1'b1;
    opcode_i   <= op;
    pixel_x_i  <= x;
    pixel_y_i  <= y;
    pixel_on_i <= on;
    do @(posedge clk_i); while (busy_o);
    op_counts[op]++;
  endtask

  // Bursts of back-to-back requests separated by random gaps or by none.
  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(7, 1);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(30, 1);
    end
  endtask

  task automatic wait_all_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (results_outstanding != 0);
  endtask

  task automatic write_ctrl_bytes(input logic [7:0] cmd_val, input logic [7:0] data_val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_CMD_CTRL;
    cfg_wdata_i <= cmd_val;
    @(posedge clk_i);
    cfg_idx_i   <= REG_DATA_CTRL;
    cfg_wdata_i <= data_val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned roll;
    logic [1:0]  op;
    logic [7:0]  x, y;
    logic        on;
    logic [7:0]  cmd_val, data_val;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    opcode_i    = OP_DRAW;
    pixel_x_i   = '0;
    pixel_y_i   = '0;
    pixel_on_i  = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_CMD_CTRL;
    cfg_wdata_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // command transfer of page 0 with reset control bytes
    repeat (4) begin
      send_request(OP_FLUSH, 8'hFF, 8'hFF, 1'b1);
      pace();
    end
    send_request(OP_DRAW, 8'd0, 8'd0, 1'b1);
    pace();
    send_request(OP_DRAW, 8'(PanelWidth - 1), 8'(PanelHeight - 1), 1'b1);
    pace();
    send_request(OP_DRAW, 8'(PanelWidth), 8'd0, 1'b1);
    pace();
    send_request(OP_DRAW, 8'd0, 8'(PanelHeight), 1'b1);
    pace();
    send_request(OP_DRAW, 8'hFF, 8'hFF, 1'b1);
    pace();
    send_request(OpUnused, 8'hFF, 8'hFF, 1'b1);
    pace();
    // data control byte, then column 0
    send_request(OP_FLUSH, 8'd0, 8'd0, 1'b0);
    pace();
    send_request(OP_FLUSH, 8'd0, 8'd0, 1'b0);
    pace();
    // draws mid-flush; the one at column 1 must show up in the next column byte
    send_request(OP_DRAW, 8'd1, 8'd0, 1'b1);
    pace();
    send_request(OP_DRAW, 8'd2, 8'd3, 1'b1);
    pace();
    send_request(OP_FLUSH, 8'd0, 8'd0, 1'b0);
    pace();
    // clear mid-flush keeps the stream position
    send_request(OP_CLEAR, 8'd0, 8'd0, 1'b0);
    pace();
    send_request(OP_FLUSH, 8'd0, 8'd0, 1'b0);
    pace();
    send_request(OP_DRAW, 8'd3, 8'd7, 1'b1);
    pace();
    send_request(OP_DRAW, 8'd3, 8'd7, 1'b0);
    pace();
    send_request(OP_DRAW, 8'd3, 8'd6, 1'b1);
    pace();
    send_request(OP_FLUSH, 8'd0, 8'd0, 1'b0);
    pace();
    wait_all_results();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0:       begin cmd_val = 8'hFF;         data_val = 8'h00;          end
        1:       begin cmd_val = 8'h00;         data_val = 8'hFF;          end
        2: begin
          cmd_val  = 8'($urandom_range(255));
          data_val = 8'($urandom_range(255));
        end
        default: begin cmd_val = CmdCtrlReset;  data_val = DataCtrlReset;  end
      endcase
      write_ctrl_bytes(cmd_val, data_val);
      for (int n = 0; n < PhaseItems; n++) begin
        roll = $urandom_range(99);
        x    = 8'($urandom_range(255));
        y    = 8'($urandom_range(255));
        on   = 1'($urandom_range(1));
        if (roll < 78) begin
          op = OP_FLUSH;
        end else if (roll < 96) begin
          op = OP_DRAW;
          if ($urandom_range(99) < 85) begin
            x = 8'($urandom_range(PanelWidth - 1));
            y = 8'($urandom_range(PanelHeight - 1));
          end else if ($urandom_range(1) == 1) begin
            x = 8'($urandom_range(255, PanelWidth));
          end else begin
            y = 8'($urandom_range(255, PanelHeight));
          end
        end else if (roll < 97) begin
          op = OP_CLEAR;
        end else begin
          op = OpUnused;
        end
        send_request(op, x, y, on);
        pace();
      end
      wait_all_results();
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d draw, %0d clear, %0d flush and %0d unused-opcode requests",
             op_counts[OP_DRAW], op_counts[OP_CLEAR], op_counts[OP_FLUSH],
             op_counts[OpUnused]);
    $display("across %0d control byte settings; flush stream wrapped %0d time(s)",
             PhaseCount + 1, flush_rounds);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
